// ===== rtl/dpm_pkg.sv =====
package dpm_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_EXEC  = 2'd2,
    OP_PROT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OOB      = 3'd1,
    ST_RD_DENY  = 3'd2,
    ST_WR_DENY  = 3'd3,
    ST_EX_DENY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FK_PRESENT = 2'd0,
    FK_FREE    = 2'd1,
    FK_VICTIM  = 2'd2
  } fault_e;

  // the spare code selects first-in first-out as well
  typedef enum logic [1:0] {
    POL_FIFO  = 2'd0,
    POL_LFU   = 2'd1,
    POL_LRU   = 2'd2,
    POL_SPARE = 2'd3
  } policy_e;

  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

endpackage

// ===== rtl/dpm_ram.sv =====
module dpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/demand_paging_mmu.sv =====
// channel  | dir | tdata fields (low bit up)                          | tuser
// s_axis   | in  | op[1:0], vaddr[17:2], prot_bits[20:18], pad        | -
// m_axis   | out | status[2:0], phys_addr[10:3], fault_kind[12:11],   | -
//          |     | victim_page[18:13], writeback_needed[19], pad      |
// cfg      | in  | replace_policy, written when cfg_we_i is high      | -
// From accept to result valid: out of bounds is answered from idle; a protection
// load runs LOOK, OUT; a hit LOOK, FINISH; a miss into a free frame LOOK, FREE,
// FINISH (lowest free frame found combinationally); a replacement VREAD, EVICT,
// QREM (arrival list removal), FREE, FINISH; count or stamp replacement first
// scans in SCAN and SCANW, one page entry a cycle. The next item is accepted at
// the edge after the result appears, together with the result being taken. After
// reset a clearing pass writes all PAGES entries with no item accepted. A result
// not yet taken holds the engine in its last state and holds off the input.
module demand_paging_mmu
  import dpm_pkg::*;
#(
  parameter int PAGE_BYTES = 16,
  parameter int PAGES      = 64,
  parameter int FRAMES     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op, vaddr, prot_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status, phys_addr, fault_kind, victim, wb
);
  localparam int OffW = $clog2(PAGE_BYTES);
  localparam int PgW  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FrW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int QcW  = $clog2(FRAMES + 1);
  localparam logic [31:0] VLimit = 32'(PAGES) * 32'(PAGE_BYTES);
  // entry: present, dirty, rights[3], frame, count[32], stamp[32]
  localparam int EW = 2 + 3 + FrW + 64;

  typedef struct packed {
    logic          present;
    logic          dirty;
    logic [2:0]    rights;
    logic [FrW-1:0] frame;
    logic [31:0]   count;
    logic [31:0]   stamp;
  } entry_t;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_READ   = 12'b000000000100,
    S_LOOK   = 12'b000000001000,
    S_FREE   = 12'b000000010000,
    S_SCAN   = 12'b000000100000,
    S_SCANW  = 12'b000001000000,
    S_VREAD  = 12'b000010000000,
    S_EVICT  = 12'b000100000000,
    S_QREM   = 12'b001000000000,
    S_FINISH = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_e;

  state_e state_q;
  logic [1:0]  policy_q;
  logic [1:0]  op_q;
  logic [PgW-1:0] page_q;
  logic [OffW-1:0] off_q;
  logic [2:0]  prot_q;
  logic [31:0] stamp_ctr_q;
  logic [FRAMES-1:0] busy_q;
  logic [PgW-1:0] queue_q [FRAMES];
  logic [QcW-1:0] fill_q;
  logic [PgW:0] idx_q;       // clear / scan counter
  logic [PgW-1:0] best_q;
  logic [31:0] bkey_q;
  logic        found_q;
  logic [FrW-1:0] frame_q;
  logic [1:0]  fault_q;
  logic [5:0]  victim_q;
  logic        wb_q;
  logic [QcW-1:0] qi_q;
  logic        qhit_q;
  entry_t      cur_q;
  logic        out_valid_q;
  logic [19:0] out_q;

  logic        we;
  logic [PgW-1:0] waddr, raddr;
  entry_t      wdata, rdata;
  logic [EW-1:0] rraw;

  dpm_ram #(.Width(EW), .Depth(PAGES)) u_pages (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rraw)
  );
  assign rdata = entry_t'(rraw);

  logic [1:0]  in_op;
  logic [15:0] in_va;
  assign in_op = s_axis_tdata[1:0];
  assign in_va = s_axis_tdata[17:2];

  // output register is free when empty or being taken this cycle
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q};

  // lowest free frame
  logic [FrW-1:0] free_idx;
  logic           free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = FrW'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [31:0] key;
  assign key = (policy_q == POL_LFU) ? rdata.count : rdata.stamp;
  logic is_fifo;
  assign is_fifo = !(policy_q == POL_LFU || policy_q == POL_LRU);

  entry_t look_ent;
  always_comb begin
    look_ent = rdata;
    if (op_q == OP_PROT) look_ent.rights = prot_q;
  end

  entry_t upd;
  logic [2:0] st;
  logic [7:0] pa;
  always_comb begin
    upd = cur_q;
    st = ST_OK;
    upd.stamp = stamp_ctr_q;
    if (cur_q.count != CountMax) upd.count = cur_q.count + 32'd1;
    case (op_q)
      OP_READ:  if (!cur_q.rights[0]) st = ST_RD_DENY;
      OP_WRITE: if (!cur_q.rights[1]) st = ST_WR_DENY; else upd.dirty = 1'b1;
      default:  if (!cur_q.rights[2]) st = ST_EX_DENY;
    endcase
    pa = 8'((32'(cur_q.frame) * 32'(PAGE_BYTES)) + 32'(off_q));
  end

  always_comb begin
    we = 1'b0;
    waddr = page_q;
    wdata = cur_q;
    raddr = page_q;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = idx_q[PgW-1:0];
        wdata = '0;
      end
      S_IDLE: raddr = PgW'(in_va >> OffW);
      S_SCAN: raddr = idx_q[PgW-1:0];
      S_SCANW: raddr = idx_q[PgW-1:0];
      S_VREAD: raddr = best_q;
      S_EVICT: begin
        we = 1'b1;
        waddr = best_q;
        wdata = rdata;
        wdata.present = 1'b0;
        wdata.dirty = 1'b0;
        wdata.count = '0;
        wdata.stamp = '0;
      end
      S_FINISH: begin
        we = 1'b1;
        wdata = upd;
      end
      // protection load writes the new rights
      S_OUT: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      policy_q <= POL_FIFO;
      stamp_ctr_q <= '0;
      busy_q <= '0;
      fill_q <= '0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == (PgW+1)'(PAGES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          op_q <= in_op;
          page_q <= PgW'(in_va >> OffW);
          off_q <= in_va[OffW-1:0];
          prot_q <= s_axis_tdata[20:18];
          if (32'(in_va) >= VLimit) begin
            out_q <= {17'd0, ST_OOB};
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          cur_q <= look_ent;
          fault_q <= FK_PRESENT;
          victim_q <= '0;
          wb_q <= 1'b0;
          if (op_q == OP_PROT) begin
            state_q <= S_OUT;
          end else if (rdata.present) begin
            state_q <= S_FINISH;
          end else if (free_any) begin
            busy_q[free_idx] <= 1'b1;
            frame_q <= free_idx;
            fault_q <= FK_FREE;
            state_q <= S_FREE;
          end else begin
            fault_q <= FK_VICTIM;
            idx_q <= '0;
            found_q <= 1'b0;
            if (is_fifo && fill_q != '0 && 32'(queue_q[0]) < 32'(PAGES)) begin
              best_q <= queue_q[0];
              state_q <= S_VREAD;
            end else begin
              best_q <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + 1'b1;
          state_q <= S_SCANW;
        end
        S_SCANW: begin
          // rdata is the entry at idx_q-1
          if (rdata.present && (is_fifo ? !found_q : (!found_q || key < bkey_q))) begin
            best_q <= PgW'(idx_q - 1'b1);
            bkey_q <= key;
            found_q <= 1'b1;
          end
          if (idx_q == (PgW+1)'(PAGES)) state_q <= S_VREAD;
          else idx_q <= idx_q + 1'b1;
        end
        S_VREAD: state_q <= S_EVICT;
        S_EVICT: begin
          frame_q <= rdata.frame;
          victim_q <= 6'(best_q);
          wb_q <= rdata.dirty;
          qi_q <= '0;
          qhit_q <= 1'b0;
          state_q <= S_QREM;
        end
        S_QREM: begin
          // one slot per cycle: find the victim, then shift down
          if (qi_q >= fill_q) begin
            if (qhit_q) fill_q <= fill_q - 1'b1;
            state_q <= S_FREE;
          end else begin
            if (qhit_q) begin
              if (qi_q > '0) queue_q[qi_q[FrW-1:0] - 1'b1] <= queue_q[qi_q[FrW-1:0]];
            end else if (queue_q[qi_q[FrW-1:0]] == best_q) begin
              qhit_q <= 1'b1;
            end
            qi_q <= qi_q + 1'b1;
          end
        end
        S_FREE: begin
          cur_q.present <= 1'b1;
          cur_q.dirty <= 1'b0;
          cur_q.count <= '0;
          cur_q.frame <= frame_q;
          if (fill_q < QcW'(FRAMES)) begin
            queue_q[fill_q[FrW-1:0]] <= page_q;
            fill_q <= fill_q + 1'b1;
          end
          state_q <= S_FINISH;
        end
        S_FINISH: if (out_free) begin
          stamp_ctr_q <= stamp_ctr_q + 32'd1;
          out_q <= {wb_q, victim_q, fault_q, pa, st};
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_OUT: if (out_free) begin
          out_q <= {17'd0, ST_OK};
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QcW'(FRAMES)) else $error("arrival list overflow");
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |=> out_valid_q) else $error("result lost");
`endif
endmodule
